/* src/nhmf_pkg.sv */
// nhmf_pkg: shared types and constants for the note hole mute filter
// holds item structs, command/section/role codes and state encoding
// no dependencies
package nhmf_pkg;

    // default window table capacity
    localparam int NHMF_MAX_WINDOWS = 64;

    // configuration register indexes
    localparam int          CFG_INDEX_W        = 1;
    localparam int          CFG_DATA_W         = 16;
    localparam logic [0:0]  REG_TRACK_ROLE     = 1'b0;
    localparam logic [0:0]  REG_TICKS_PER_BEAT = 1'b1;

    // reset values of the configuration registers
    localparam logic [3:0]  RESET_TRACK_ROLE     = 4'd0;
    localparam logic [15:0] RESET_TICKS_PER_BEAT = 16'd480;

    // command codes
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_SECTION = 2'd1;
    localparam logic [1:0] CMD_NOTE    = 2'd2;

    // section kinds
    localparam logic [1:0] SEC_CHORUS = 2'd1;
    localparam logic [1:0] SEC_BRIDGE = 2'd2;

    // track roles that bound the window rules
    localparam logic [3:0] ROLE_MOTIF  = 4'd3;
    localparam logic [3:0] ROLE_GUITAR = 4'd6;
    localparam logic [3:0] ROLE_BASS   = 4'd8;

    // input item
    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  section_kind;
        logic        peak_is_max;
        logic [31:0] onset_tick;
        logic [31:0] length_ticks;
        logic [6:0]  pitch_in;
        logic [6:0]  velocity_in;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [31:0] note_start;
        logic [31:0] note_duration;
        logic [6:0]  pitch_out;
        logic [6:0]  velocity_out;
        logic        windows_overflowed;
    } t_out_item;

    // one stored mute window
    typedef struct packed {
        logic [31:0] win_begin;
        logic [31:0] win_finish;
    } t_window;

    // control state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SECT = 4'b0010,
        ST_WALK = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

/* src/nhmf_window_ram.sv */
// nhmf_window_ram: window table storage, one write and one read port
// synchronous read; uses nhmf_pkg
module nhmf_window_ram
    import nhmf_pkg::*;
#(
    parameter int DEPTH  = NHMF_MAX_WINDOWS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_window           i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_window           o_rd_data
);

    t_window r_mem [DEPTH];
    t_window r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/note_hole_mute_filter.sv */
// note_hole_mute_filter: top level of the note hole mute filter
// depends on nhmf_pkg and nhmf_window_ram
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries commands:
//   clear the window table, add a section, or filter a note. Output channel
//   (o_out_valid / i_out_stall / o_out_item) carries retained notes only.
//   Configuration (i_cfg_we, i_cfg_index, i_cfg_data) sets track role and
//   ticks per beat; write only while the block is idle.
// Timing:
//   Clear and unused commands finish in the accept cycle.
//   A section is accepted, then its window is built and written in ST_SECT.
//   A note is accepted, then walks the stored windows in ST_WALK, reading
//   one window per cycle from the table memory, whose registered read
//   is hidden by reading the next entry while the current is checked;
//   a hit ends the walk early. With an empty table a note goes to ST_EMIT.
//   There the result is loaded into the output register once it is free.
// Reset and stall:
//   Synchronous active-low reset empties the table (count zero), clears the
//   overflow flag and the output valid flag and restores register defaults.
//   No clearing pass is needed. A stalled result holds in the output
//   register; the block keeps accepting items and only waits at the end of
//   a note walk until the output register is free.
module note_hole_mute_filter
    import nhmf_pkg::*;
#(
    parameter int MAX_WINDOWS = NHMF_MAX_WINDOWS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    // control registers
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [3:0]       r_role;
    logic [15:0]      r_tpb;

    // item payload registers
    logic [31:0] r_start, r_len, r_dur, n_dur;
    logic [32:0] r_end, n_end;
    logic [1:0]  r_kind;
    logic        r_peak;
    logic [6:0]  r_pitch, r_vel;
    t_out_item   r_out_item;

    // memory interface
    logic             w_we;
    logic [IDX_W-1:0] w_wr_addr;
    t_window          w_wr_data;
    logic [IDX_W-1:0] w_rd_addr;
    t_window          w_rd_data;

    // datapath helpers
    logic        w_accept;
    logic        w_out_free;
    logic        w_load_out;
    logic [16:0] w_two_beats;
    logic        w_chorus_role, w_bridge_role;
    logic        w_hit, w_cut, w_last;
    logic [CNT_W-1:0] w_idx_inc;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_two_beats = {r_tpb, 1'b0};

    // role classes for window rules
    always_comb begin
        w_chorus_role = r_role inside {[ROLE_MOTIF:ROLE_GUITAR]};
        w_bridge_role = r_role inside {[ROLE_MOTIF:ROLE_BASS]};
    end

    // window check of the walk against the entry read last cycle
    assign w_hit     = (r_start >= w_rd_data.win_begin) && (r_start < w_rd_data.win_finish);
    assign w_cut     = (r_start < w_rd_data.win_begin) && (r_end > {1'b0, w_rd_data.win_begin});
    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_last    = (w_idx_inc == r_count);

    // read address: entry 0 on note accept, next entry during the walk
    assign w_rd_addr = (r_state == ST_WALK) ? w_idx_inc[IDX_W-1:0] : '0;

    // section window build and table write, and table clear
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_count[IDX_W-1:0];
        w_wr_data = '0;
        n_count   = r_count;
        n_ovf     = r_ovf;
        if (r_state == ST_SECT && r_len >= 32'(w_two_beats)) begin
            if (r_kind == SEC_CHORUS && r_peak && w_chorus_role) begin
                w_wr_data.win_begin  = r_end[31:0] - 32'(w_two_beats);
                w_wr_data.win_finish = r_end[31:0];
                w_we = 1'b1;
            end else if (r_kind == SEC_BRIDGE && w_bridge_role) begin
                w_wr_data.win_begin  = r_start;
                w_wr_data.win_finish = r_start + 32'(w_two_beats);
                w_we = 1'b1;
            end
            if (w_we) begin
                if (r_count == CNT_W'(MAX_WINDOWS)) begin
                    w_we  = 1'b0;
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
        if (w_accept && i_in_item.command == CMD_CLEAR) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_dur      = r_dur;
        n_end      = r_end;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    case (i_in_item.command)
                        CMD_SECTION: n_state = ST_SECT;
                        CMD_NOTE:    n_state = (r_count == '0) ? ST_EMIT : ST_WALK;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SECT: begin
                n_state = ST_IDLE;
            end
            ST_WALK: begin
                n_idx = w_idx_inc;
                if (w_cut) begin
                    n_dur = w_rd_data.win_begin - r_start;
                    n_end = {1'b0, w_rd_data.win_begin};
                end
                if (w_hit) begin
                    n_state = ST_IDLE;
                end else if (w_last) begin
                    // a cut never leaves zero, so only an uncut zero drops
                    n_state = (!w_cut && r_dur == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_role      <= RESET_TRACK_ROLE;
            r_tpb       <= RESET_TICKS_PER_BEAT;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_index == REG_TRACK_ROLE) begin
                r_role <= i_cfg_data[3:0];
            end
            if (i_cfg_we && i_cfg_index == REG_TICKS_PER_BEAT) begin
                r_tpb <= i_cfg_data[15:0];
            end
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start <= i_in_item.onset_tick;
            r_len   <= i_in_item.length_ticks;
            r_dur   <= i_in_item.length_ticks;
            r_end   <= {1'b0, i_in_item.onset_tick} + {1'b0, i_in_item.length_ticks};
            r_kind  <= i_in_item.section_kind;
            r_peak  <= i_in_item.peak_is_max;
            r_pitch <= i_in_item.pitch_in;
            r_vel   <= i_in_item.velocity_in;
        end else begin
            r_dur <= n_dur;
            r_end <= n_end;
        end
        if (w_load_out) begin
            r_out_item.note_start         <= r_start;
            r_out_item.note_duration      <= r_dur;
            r_out_item.pitch_out          <= r_pitch;
            r_out_item.velocity_out       <= r_vel;
            r_out_item.windows_overflowed <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // window table
    nhmf_window_ram #(
        .DEPTH  (MAX_WINDOWS),
        .ADDR_W (IDX_W)
    ) u_window_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

/* src/nhmf_checker.sv */
// nhmf_checker: port-level checks for note_hole_mute_filter
// uses nhmf_pkg; bound to the top level at the end of this file
module nhmf_checker
    import nhmf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // reset leaves the block idle with an empty output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // section and note items leave the block busy right after acceptance
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_item.command == CMD_SECTION || i_in_item.command == CMD_NOTE)
        |=> o_in_stall)
        else $error("block free right after a section or note item");

    // clear and unused commands finish at once
    a_clear_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_item.command != CMD_SECTION && i_in_item.command != CMD_NOTE
        |=> !o_in_stall)
        else $error("block busy after a clear item");

endmodule

bind note_hole_mute_filter nhmf_checker u_nhmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

/* sim/note_hole_mute_filter_tb.sv */
// note_hole_mute_filter_tb: self-checking bench for the note hole mute filter
// predicts retained notes from the window table it keeps; scoreboard class inside
// depends on nhmf_pkg and note_hole_mute_filter
module note_hole_mute_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nhmf_pkg::*;

    // codes the package does not name
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam logic [1:0] SEC_OTHER      = 2'd0;
    localparam logic [1:0] SEC_UNUSED     = 2'd3;
    localparam logic [3:0] ROLE_VOCAL     = 4'd0;
    localparam logic [3:0] ROLE_ARPEGGIO  = 4'd4;
    localparam logic [3:0] ROLE_AUX       = 4'd5;
    localparam logic [3:0] ROLE_CHORD     = 4'd7;
    localparam logic [3:0] ROLE_OTHER     = 4'd9;
    localparam logic [3:0] ROLE_UNUSED    = 4'd15;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 2 * NHMF_MAX_WINDOWS + 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int MAX_REPORTS     = 200;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // window table predictor and store of retained notes
    class mute_window_scoreboard;
        logic [31:0] win_begin  [NHMF_MAX_WINDOWS];
        logic [31:0] win_finish [NHMF_MAX_WINDOWS];
        int unsigned win_count;
        logic        overflow;
        logic [3:0]  role;
        logic [15:0] beat_ticks;
        t_out_item   retained_notes[$];
        int          errors;

        function new();
            win_count  = 0;
            overflow   = 1'b0;
            role       = RESET_TRACK_ROLE;
            beat_ticks = RESET_TICKS_PER_BEAT;
            errors     = 0;
        endfunction

        function void add_window(logic [31:0] b, logic [31:0] f);
            if (win_count >= NHMF_MAX_WINDOWS) begin
                overflow = 1'b1;
            end else begin
                win_begin[win_count]  = b;
                win_finish[win_count] = f;
                win_count++;
            end
        endfunction

        // update the table or predict the note for one accepted item
        function void apply_item(t_in_item it);
            logic [31:0] two_beats;
            logic [31:0] sec_end;
            logic [31:0] dur;
            logic [32:0] tail_tick;
            logic        dropped;
            t_out_item   note;
            two_beats = {15'd0, beat_ticks, 1'b0};
            case (it.command)
                CMD_CLEAR: begin
                    win_count = 0;
                    overflow  = 1'b0;
                end
                CMD_SECTION: begin
                    sec_end = it.onset_tick + it.length_ticks;
                    if (it.length_ticks >= two_beats) begin
                        if (it.section_kind == SEC_CHORUS && it.peak_is_max
                                && role >= ROLE_MOTIF && role <= ROLE_GUITAR)
                            add_window(sec_end - two_beats, sec_end);
                        else if (it.section_kind == SEC_BRIDGE
                                && role >= ROLE_MOTIF && role <= ROLE_BASS)
                            add_window(it.onset_tick, it.onset_tick + two_beats);
                    end
                end
                CMD_NOTE: begin
                    dur     = it.length_ticks;
                    dropped = 1'b0;
                    // walk windows in insertion order, cutting as we go
                    for (int i = 0; i < win_count; i++) begin
                        tail_tick = {1'b0, it.onset_tick} + {1'b0, dur};
                        if (it.onset_tick >= win_begin[i] && it.onset_tick < win_finish[i]) begin
                            dropped = 1'b1;
                            break;
                        end
                        if (it.onset_tick < win_begin[i] && tail_tick > {1'b0, win_begin[i]})
                            dur = win_begin[i] - it.onset_tick;
                    end
                    if (win_count != 0 && dur == 32'd0)
                        dropped = 1'b1;
                    if (!dropped) begin
                        note.note_start         = it.onset_tick;
                        note.note_duration      = dur;
                        note.pitch_out          = it.pitch_in;
                        note.velocity_out       = it.velocity_in;
                        note.windows_overflowed = overflow;
                        retained_notes = {retained_notes, note};
                    end
                end
                default: begin
                    // unused command does nothing
                end
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h",
                             $time, field, want, got);
            end
        endfunction

        // compare one accepted result against the oldest prediction
        function void check_note(t_out_item got);
            t_out_item want;
            if (retained_notes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected note, expected none actual start 0x%08h",
                             $time, got.note_start);
                return;
            end
            want = retained_notes.pop_front();
            compare("note_start", want.note_start, got.note_start);
            compare("note_duration", want.note_duration, got.note_duration);
            compare("pitch_out", 32'(want.pitch_out), 32'(got.pitch_out));
            compare("velocity_out", 32'(want.velocity_out), 32'(got.velocity_out));
            compare("windows_overflowed", 32'(want.windows_overflowed),
                    32'(got.windows_overflowed));
        endfunction

        function int pending();
            return retained_notes.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    mute_window_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_armed = 1'b0;
    bit  hold_used = 1'b0;
    int  hold_left = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;
    logic      in_fire = 1'b0;
    logic      out_fire = 1'b0;
    t_in_item  in_taken;
    t_out_item out_taken;

    note_hole_mute_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sample handshakes mid-cycle, once everything has settled
    always @(negedge i_clk) begin
        in_fire   = rst_n && in_valid && !in_stall;
        in_taken  = in_item;
        out_fire  = rst_n && out_valid && !out_stall;
        out_taken = out_item;
    end

    // score transfers and watch for a hang
    always @(posedge i_clk) begin
        if (in_fire)
            sb.apply_item(in_taken);
        if (out_fire)
            sb.check_note(out_taken);
        if (in_fire || out_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("note_hole_mute_filter_tb NOT OK");
            $finish;
        end
    end

    // receiver: random stall, or one long hold-off when armed
    always @(posedge i_clk) begin
        if (hold_armed && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_in_item make_item(logic [1:0] cmd, logic [1:0] kind, logic peak,
                                           logic [31:0] start, logic [31:0] len,
                                           logic [6:0] pitch, logic [6:0] vel);
        t_in_item it;
        it.command      = cmd;
        it.section_kind = kind;
        it.peak_is_max  = peak;
        it.onset_tick   = start;
        it.length_ticks = len;
        it.pitch_in     = pitch;
        it.velocity_in  = vel;
        return it;
    endfunction

    // offer one item after a random gap and wait until it is taken
    task automatic send_item(input t_in_item it);
        int gap;
        bit taken;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !in_stall;
            @(posedge i_clk);
        end
        if (it.command != CMD_UNUSED)
            items_sent++;
    endtask

    // both registers written back to back while the block is idle
    task automatic set_config(logic [3:0] role, logic [15:0] beat);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TRACK_ROLE;
        cfg_data  <= CFG_DATA_W'(role);
        @(posedge i_clk);
        cfg_index <= REG_TICKS_PER_BEAT;
        cfg_data  <= beat;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.role       = role;
        sb.beat_ticks = beat;
    endtask

    // wait for every predicted note, then let dropped walks finish
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // hand-picked items, motif role at 480 ticks per beat (windows of 960)
    task automatic run_directed();
        // empty table: zero and maximal durations pass unchanged
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd100, 32'd0, 7'd127, 7'd127));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            7'd0, 7'd0));
        send_item(make_item(CMD_UNUSED, SEC_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            7'd127, 7'd127));
        // chorus tail and bridge head windows, plus sections that add none
        send_item(make_item(CMD_SECTION, SEC_CHORUS, 1'b1, 32'd1000, 32'd5000, 7'd1, 7'd2));
        send_item(make_item(CMD_SECTION, SEC_CHORUS, 1'b0, 32'd20000, 32'd5000, 7'd1, 7'd2));
        send_item(make_item(CMD_SECTION, SEC_BRIDGE, 1'b0, 32'd10000, 32'd960, 7'd1, 7'd2));
        send_item(make_item(CMD_SECTION, SEC_BRIDGE, 1'b1, 32'd30000, 32'd959, 7'd1, 7'd2));
        send_item(make_item(CMD_SECTION, SEC_OTHER, 1'b1, 32'd40000, 32'd5000, 7'd1, 7'd2));
        send_item(make_item(CMD_SECTION, SEC_UNUSED, 1'b1, 32'd50000, 32'd5000, 7'd1, 7'd2));
        // wrapped section ends give inverted windows
        send_item(make_item(CMD_SECTION, SEC_CHORUS, 1'b1, 32'hFFFF_FF00, 32'h200, 7'd3, 7'd4));
        send_item(make_item(CMD_SECTION, SEC_BRIDGE, 1'b0, 32'hFFFF_FE00, 32'd1000, 7'd3, 7'd4));
        // inside, crossing, touching, past the end
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd5100, 32'd50, 7'd60, 7'd90));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd4000, 32'd2000, 7'd61, 7'd91));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd4000, 32'd1040, 7'd62, 7'd92));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd6000, 32'd10, 7'd63, 7'd93));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd0, 32'hFFFF_FFFF, 7'd64, 7'd94));
        // note end beyond 32 bits cut by an inverted window
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'hFFFF_FC00, 32'h1000, 7'd65, 7'd95));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'hFFFF_FD40, 32'd5, 7'd66, 7'd96));
        // zero durations with windows present are dropped
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd5040, 32'd0, 7'd67, 7'd97));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd7000, 32'd0, 7'd68, 7'd98));
        // clear empties the table
        send_item(make_item(CMD_CLEAR, SEC_OTHER, 1'b0, 32'd0, 32'd0, 7'd0, 7'd0));
        send_item(make_item(CMD_NOTE, SEC_OTHER, 1'b0, 32'd5100, 32'd50, 7'd69, 7'd99));
    endtask

    // one song: clear, sections, then notes around them; sometimes plain noise
    task automatic play_song();
        logic [31:0] two_beats;
        logic [31:0] span;
        logic [31:0] base;
        logic [31:0] start;
        logic [31:0] len;
        logic [1:0]  kind;
        int          n_sect;
        int          n_note;
        int          pick;
        bit          crowded;
        two_beats = {15'd0, sb.beat_ticks, 1'b0};
        span      = two_beats * 4 + 32'd64;
        pick      = $urandom_range(9);
        if (pick < 2)
            base = 32'hFFFF_FFFF - $urandom_range(span);
        else if (pick < 4)
            base = $urandom_range(span);
        else
            base = $urandom;

        // noise: any field value, unused commands included
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 4))
                send_item(make_item(2'($urandom_range(3)), 2'($urandom_range(3)),
                                    1'($urandom_range(1)), $urandom, $urandom,
                                    7'($urandom_range(127)), 7'($urandom_range(127))));
            return;
        end

        if ($urandom_range(99) < 85)
            send_item(make_item(CMD_CLEAR, 2'($urandom_range(3)), 1'($urandom_range(1)),
                                $urandom, $urandom, 7'($urandom_range(127)),
                                7'($urandom_range(127))));

        // a crowded song can overrun the table, for roles that take bridge windows
        crowded = ($urandom_range(9) == 0);
        n_sect  = crowded ? $urandom_range(70, 90) : $urandom_range(1, 6);
        repeat (n_sect) begin
            pick = $urandom_range(9);
            if (crowded)
                kind = SEC_BRIDGE;
            else if (pick < 4)
                kind = SEC_CHORUS;
            else if (pick < 8)
                kind = SEC_BRIDGE;
            else if (pick == 8)
                kind = SEC_OTHER;
            else
                kind = SEC_UNUSED;
            start = base + $urandom_range(span);
            pick  = $urandom_range(99);
            if (pick < 70 || crowded)
                len = two_beats + $urandom_range(span);
            else if (pick < 85)
                len = two_beats - $urandom_range(1, 2);
            else
                len = $urandom;
            send_item(make_item(CMD_SECTION, kind, $urandom_range(5) != 0, start, len,
                                7'($urandom_range(127)), 7'($urandom_range(127))));
        end

        n_note = $urandom_range(2, 10);
        repeat (n_note) begin
            start = base - (span >> 2) + $urandom_range(span + (span >> 1));
            pick  = $urandom_range(99);
            if (pick < 60)
                len = $urandom_range(span >> 1);
            else if (pick < 70)
                len = 32'd0;
            else if (pick < 85)
                len = $urandom;
            else
                len = $urandom_range(two_beats * 2);
            send_item(make_item(CMD_NOTE, 2'($urandom_range(3)), 1'($urandom_range(1)),
                                start, len, 7'($urandom_range(127)),
                                7'($urandom_range(127))));
        end
    endtask

    task automatic run_phase(logic [3:0] role, logic [15:0] beat, t_idle_mode mode,
                             bit pressure, bit directed);
        int first;
        set_config(role, beat);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default:       begin send_idle_pct = 17; recv_stall_pct = 17; end
        endcase
        if (pressure)
            hold_armed = 1'b1;
        if (directed)
            run_directed();
        first = items_sent;
        while (items_sent - first < ITEMS_PER_PHASE)
            play_song();
        drain();
    endtask

    // reset, then a sweep of register settings and idle patterns
    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(ROLE_MOTIF,    16'd480,   IDLE_NONE,     1'b0, 1'b1);
        run_phase(ROLE_CHORD,    16'd1,     IDLE_SENDER,   1'b0, 1'b0);
        run_phase(ROLE_GUITAR,   16'd65535, IDLE_RECEIVER, 1'b0, 1'b0);
        run_phase(ROLE_BASS,     16'd0,     IDLE_BOTH,     1'b0, 1'b0);
        run_phase(ROLE_ARPEGGIO, 16'd100,   IDLE_NONE,     1'b1, 1'b0);
        run_phase(ROLE_VOCAL,    16'd480,   IDLE_BOTH,     1'b0, 1'b0);
        run_phase(ROLE_UNUSED,   16'd7,     IDLE_SENDER,   1'b0, 1'b0);
        run_phase(ROLE_AUX,      16'd2,     IDLE_RECEIVER, 1'b0, 1'b0);
        run_phase(ROLE_OTHER,    16'd3,     IDLE_NONE,     1'b0, 1'b0);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("note_hole_mute_filter_tb OK");
        else
            $display("note_hole_mute_filter_tb NOT OK");
        $finish;
    end

endmodule
